// File: design/kpl_pkg.sv
package kpl_pkg;

    localparam int KEY_W = 5;

    localparam logic [KEY_W-1:0] KEY_NONE  = 5'd0;
    localparam logic [KEY_W-1:0] KEY_DIG0  = 5'd1;
    localparam logic [KEY_W-1:0] KEY_TWO   = 5'd3;
    localparam logic [KEY_W-1:0] KEY_EIGHT = 5'd9;
    localparam logic [KEY_W-1:0] KEY_DIG9  = 5'd10;
    localparam logic [KEY_W-1:0] KEY_A     = 5'd11;
    localparam logic [KEY_W-1:0] KEY_B     = 5'd12;
    localparam logic [KEY_W-1:0] KEY_C     = 5'd13;
    localparam logic [KEY_W-1:0] KEY_D     = 5'd14;
    localparam logic [KEY_W-1:0] KEY_STAR  = 5'd15;
    localparam logic [KEY_W-1:0] KEY_HASH  = 5'd16;

    typedef enum logic [2:0] {
        MODE_MAIN    = 3'd0,
        MODE_PROG    = 3'd1,
        MODE_OPER    = 3'd2,
        MODE_UNLOCK  = 3'd3,
        MODE_REJECT  = 3'd4,
        MODE_REMOVE  = 3'd5,
        MODE_ADD     = 3'd6,
        MODE_ERASE   = 3'd7
    } mode_t;

    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_ENROLL = 2'd1;
    localparam logic [1:0] REQ_ERASE  = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_SAVED    = 3'd1;
    localparam logic [2:0] EV_ACCEPTED = 3'd2;
    localparam logic [2:0] EV_REJECTED = 3'd3;
    localparam logic [2:0] EV_DELETED  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic scan_step;
        logic commit;
    } kpl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_need;
        logic scan_last;
        logic out_free;
    } kpl_sts_t;

endpackage

// File: design/kpl_if.sv
interface kpl_poll_if;
    logic       valid;
    logic       ready;
    logic [4:0] key_code;
    logic       finger_match;

    modport source (output valid, key_code, finger_match, input ready);
    modport sink   (input valid, key_code, finger_match, output ready);
endinterface

interface kpl_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic        lock_open;
    logic [2:0]  digit_count;
    logic [15:0] entered_digits;
    logic        menu_choice;
    logic [1:0]  slot_cursor;
    logic [1:0]  sensor_request;
    logic [2:0]  event_res;

    modport source (output valid, mode, lock_open, digit_count, entered_digits, menu_choice,
                    slot_cursor, sensor_request, event_res, input ready);
    modport sink   (input valid, mode, lock_open, digit_count, entered_digits, menu_choice,
                    slot_cursor, sensor_request, event_res, output ready);
endinterface

// File: design/keypad_pin_lock_controller.sv
// Keypad PIN lock controller.
// poll channel: one debounced keypad poll (key_code, finger_match) per item.
// result channel: one item per poll with the mode after that poll, the lock
// state, the entry buffer, menu and slot cursors, a one-item sensor request
// and an event code.
// Timing: a poll is latched when taken, and its result is registered when the
// controller commits it. PIN submit in operating mode and the last digit of a
// new PIN walk the slot array one slot per cycle before the commit. A new poll
// is taken only after the last one has been committed.
// Reset puts the block in the main menu with an empty entry and all slots
// empty; poll.ready is high right after reset.
// A stalled result is held in the output register; the next poll is still
// taken and worked up to its commit, which then waits until result.ready.
module keypad_pin_lock_controller #(
    parameter int SLOT_COUNT = 3,
    parameter int PIN_LENGTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    kpl_poll_if.sink     poll,
    kpl_result_if.source result
);
    import kpl_pkg::*;

    kpl_cmd_t cmd;
    kpl_sts_t sts;

    kpl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .poll_valid (poll.valid),
        .poll_ready (poll.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    kpl_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .PIN_LENGTH (PIN_LENGTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_code     (poll.key_code),
        .finger_match (poll.finger_match),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result)
    );

endmodule

// File: design/kpl_ctrl.sv
module kpl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             poll_valid,
    output logic             poll_ready,
    input  kpl_pkg::kpl_sts_t sts,
    output kpl_pkg::kpl_cmd_t cmd
);
    import kpl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    logic   accept;

    assign accept     = poll_valid && ready_reg;
    assign poll_ready = ready_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.scan_need ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign cmd.latch     = accept;
    assign cmd.scan_step = (state_reg == S_SCAN);
    assign cmd.commit    = (state_reg == S_COMMIT) && sts.out_free;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (state_reg == S_IDLE))
        else $error("poll ready out of step with controller state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start processing");

    a_commit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) && !sts.out_free |=> state_reg == S_COMMIT)
        else $error("commit dropped while output register busy");

endmodule

// File: design/kpl_dp.sv
module kpl_dp #(
    parameter int SLOT_COUNT = 3,
    parameter int PIN_LENGTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        key_code,
    input  logic              finger_match,
    input  kpl_pkg::kpl_cmd_t cmd,
    output kpl_pkg::kpl_sts_t sts,
    kpl_result_if.source      result
);
    import kpl_pkg::*;

    localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W    = $clog2(PIN_LENGTH + 1);
    localparam int PIN_BITS = 4 * PIN_LENGTH;

    localparam logic [CNT_W-1:0]  PL_C    = CNT_W'(PIN_LENGTH);
    localparam logic [CNT_W-1:0]  PL_M1   = CNT_W'(PIN_LENGTH - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    // architectural state
    mode_t               mode_reg, mode_next;
    logic [PIN_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                choice_reg, choice_next;
    logic [SLOT_W-1:0]   cursor_reg, cursor_next;
    logic [KEY_W-1:0]    prev_key_reg, prev_key_next;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [PIN_BITS-1:0] value_reg [SLOT_COUNT];

    // latched item and scan results
    logic [KEY_W-1:0]    key_reg;
    logic                finger_reg;
    logic [SLOT_W-1:0]   scan_idx_reg;
    logic                match_reg;
    logic                empty_found_reg;
    logic [SLOT_W-1:0]   empty_idx_reg;

    // output register
    logic                out_valid_reg;
    logic [2:0]          out_mode_reg;
    logic                out_lock_reg;
    logic [2:0]          out_count_reg;
    logic [15:0]         out_digits_reg;
    logic                out_choice_reg;
    logic [1:0]          out_cursor_reg;
    logic [1:0]          out_request_reg;
    logic [2:0]          out_event_reg;

    logic [KEY_W-1:0]    key_in;
    logic                in_digit;
    logic                key_digit;
    logic                can_push;
    logic                full_after;
    logic [PIN_BITS-1:0] buf_push;
    logic                store_en;
    logic                delete_en;
    logic [1:0]          request_next;
    logic [2:0]          event_next;
    logic [31:0]         buf_wide;
    logic [3:0]          cnt_wide;

    // unused codes above hash read as no key
    assign key_in   = (key_code > KEY_HASH) ? KEY_NONE : key_code;
    assign in_digit = (key_in >= KEY_DIG0) && (key_in <= KEY_DIG9);

    assign key_digit  = (key_reg >= KEY_DIG0) && (key_reg <= KEY_DIG9);
    assign can_push   = cnt_reg < PL_C;
    assign full_after = !can_push || (cnt_reg == PL_M1);

    assign sts.scan_need = ((mode_reg == MODE_OPER) && !finger_match && (key_in == KEY_HASH)
                            && (cnt_reg == PL_C))
                        || ((mode_reg == MODE_ADD) && in_digit && full_after);
    assign sts.scan_last = (scan_idx_reg == SLOT_LAST);
    assign sts.out_free  = !out_valid_reg || result.ready;

    // new digit goes into the nibble at the count position, first digit highest
    always_comb
    begin
        buf_push = buf_reg;
        for (int i = 0; i < PIN_LENGTH; i++)
        begin
            if (cnt_reg == CNT_W'(i))
            begin
                buf_push[(PIN_LENGTH - 1 - i) * 4 +: 4] = 4'(key_reg - KEY_DIG0);
            end
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        choice_next   = choice_reg;
        cursor_next   = cursor_reg;
        prev_key_next = prev_key_reg;
        store_en      = 1'b0;
        delete_en     = 1'b0;
        request_next  = REQ_NONE;
        event_next    = EV_NONE;

        unique case (mode_reg)
            MODE_MAIN:
            begin
                if ((key_reg != KEY_NONE) && (key_reg != prev_key_reg))
                begin
                    if (key_reg == KEY_TWO)
                        choice_next = 1'b0;
                    else if (key_reg == KEY_EIGHT)
                        choice_next = 1'b1;
                    else if (key_reg == KEY_HASH)
                        mode_next = choice_reg ? MODE_PROG : MODE_OPER;
                end
                prev_key_next = key_reg;
            end
            MODE_PROG:
            begin
                if (key_reg == KEY_STAR)
                    mode_next = MODE_MAIN;
                else if (key_reg == KEY_A)
                begin
                    buf_next  = '0;
                    cnt_next  = '0;
                    mode_next = MODE_ADD;
                end
                else if (key_reg == KEY_B)
                    mode_next = MODE_REMOVE;
                else if (key_reg == KEY_C)
                    request_next = REQ_ENROLL;
                else if (key_reg == KEY_D)
                    mode_next = MODE_ERASE;
            end
            MODE_OPER:
            begin
                if (finger_reg)
                begin
                    buf_next   = '0;
                    cnt_next   = '0;
                    mode_next  = MODE_UNLOCK;
                    event_next = EV_ACCEPTED;
                end
                else if (key_reg == KEY_STAR)
                begin
                    buf_next  = '0;
                    cnt_next  = '0;
                    mode_next = MODE_MAIN;
                end
                else if (key_digit)
                begin
                    if (can_push)
                    begin
                        buf_next = buf_push;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if ((key_reg == KEY_HASH) && (cnt_reg == PL_C))
                begin
                    mode_next  = match_reg ? MODE_UNLOCK : MODE_REJECT;
                    event_next = match_reg ? EV_ACCEPTED : EV_REJECTED;
                    buf_next   = '0;
                    cnt_next   = '0;
                end
            end
            MODE_UNLOCK:
            begin
                if (key_reg == KEY_STAR)
                    mode_next = MODE_MAIN;
            end
            MODE_REJECT:
            begin
                mode_next = MODE_OPER;
            end
            MODE_REMOVE:
            begin
                if (key_reg == KEY_STAR)
                    mode_next = MODE_PROG;
                else if (key_reg == KEY_TWO)
                begin
                    if (cursor_reg != '0)
                        cursor_next = cursor_reg - 1'b1;
                end
                else if (key_reg == KEY_EIGHT)
                begin
                    if (cursor_reg != SLOT_LAST)
                        cursor_next = cursor_reg + 1'b1;
                end
                else if (key_reg == KEY_HASH)
                begin
                    delete_en  = 1'b1;
                    event_next = EV_DELETED;
                end
            end
            MODE_ADD:
            begin
                if (key_reg == KEY_STAR)
                begin
                    buf_next  = '0;
                    cnt_next  = '0;
                    mode_next = MODE_PROG;
                end
                else if (key_digit)
                begin
                    if (can_push)
                    begin
                        buf_next = buf_push;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (full_after)
                    begin
                        // no free slot: PIN is dropped, still reported as saved
                        store_en   = empty_found_reg;
                        event_next = EV_SAVED;
                        buf_next   = '0;
                        cnt_next   = '0;
                        mode_next  = MODE_PROG;
                    end
                end
            end
            MODE_ERASE:
            begin
                if (key_reg == KEY_STAR)
                    mode_next = MODE_PROG;
                else if (key_reg == KEY_HASH)
                begin
                    request_next = REQ_ERASE;
                    mode_next    = MODE_PROG;
                end
            end
            default:
            begin
                mode_next = MODE_MAIN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_MAIN;
            buf_reg      <= '0;
            cnt_reg      <= '0;
            choice_reg   <= 1'b0;
            cursor_reg   <= '0;
            prev_key_reg <= KEY_NONE;
            valid_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            mode_reg     <= mode_next;
            buf_reg      <= buf_next;
            cnt_reg      <= cnt_next;
            choice_reg   <= choice_next;
            cursor_reg   <= cursor_next;
            prev_key_reg <= prev_key_next;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (store_en && (empty_idx_reg == SLOT_W'(i)))
                    valid_reg[i] <= 1'b1;
                else if (delete_en && (cursor_reg == SLOT_W'(i)))
                    valid_reg[i] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && store_en)
        begin
            value_reg[empty_idx_reg] <= buf_push;
        end
    end

    // one slot per cycle: match check and first-empty search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg    <= '0;
            match_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
        end
        else if (cmd.latch)
        begin
            scan_idx_reg    <= '0;
            match_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (!sts.scan_last)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (valid_reg[scan_idx_reg] && (value_reg[scan_idx_reg] == buf_reg))
                match_reg <= 1'b1;
            if (!valid_reg[scan_idx_reg] && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= scan_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            key_reg    <= key_in;
            finger_reg <= finger_match;
        end
    end

    assign buf_wide = 32'(buf_next) << (32 - PIN_BITS);
    assign cnt_wide = 4'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_mode_reg    <= mode_next;
            out_lock_reg    <= (mode_next == MODE_UNLOCK);
            out_count_reg   <= cnt_wide[2:0];
            out_digits_reg  <= buf_wide[31:16];
            out_choice_reg  <= choice_next;
            out_cursor_reg  <= 2'(cursor_next);
            out_request_reg <= request_next;
            out_event_reg   <= event_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.mode           = out_mode_reg;
    assign result.lock_open      = out_lock_reg;
    assign result.digit_count    = out_count_reg;
    assign result.entered_digits = out_digits_reg;
    assign result.menu_choice    = out_choice_reg;
    assign result.slot_cursor    = out_cursor_reg;
    assign result.sensor_request = out_request_reg;
    assign result.event_res      = out_event_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= PL_C)
        else $error("digit count beyond PIN length");

    a_lock_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_lock_reg == (out_mode_reg == MODE_UNLOCK)))
        else $error("lock output disagrees with mode");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed item produced no result");

    a_store_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && store_en |=> valid_reg[$past(empty_idx_reg)])
        else $error("stored PIN slot not marked valid");

endmodule
